@@ rtl/core/button_gesture_classifier_assert.svh @@
// Assertion macros for the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BGC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgc assertion failed");

// Next-cycle implication, disabled during reset.
`define BGC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgc assertion failed");

`endif

@@ rtl/core/bgc_pkg.sv @@
// Package: shared types and constants for the button gesture classifier.
`default_nettype none
package bgc_pkg;

   localparam int CFG_W          = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int TIMER_WIDTH_DEF = 16;

   localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
   localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd850;
   localparam logic [CFG_W-1:0] LONG_RST     = 16'd900;
   localparam logic [CFG_W-1:0] STARTUP_RST  = 16'd500;
   localparam logic [CFG_W-1:0] GUARD_RST    = 16'd100;
   localparam logic             ACTLOW_RST   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE = 3'd0,
      REG_DOUBLE   = 3'd1,
      REG_LONG     = 3'd2,
      REG_STARTUP  = 3'd3,
      REG_GUARD    = 3'd4,
      REG_ACTLOW   = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      GEST_SHORT  = 2'd0,
      GEST_LONG   = 2'd1,
      GEST_DOUBLE = 2'd2
   } gesture_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] double_window_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] startup_ignore_ms;
      logic [CFG_W-1:0] guard_ms;
      logic             active_low;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      gesture_type gesture;
   } res_type;

endpackage
`default_nettype wire

@@ rtl/core/bgc_cfg.sv @@
// Configuration register bank of the button gesture classifier.
`default_nettype none
module bgc_cfg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [bgc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bgc_pkg::CFG_W-1:0]     csr_wdata,
   output bgc_pkg::cfg_type                   cfg
);
   import bgc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_DEBOUNCE: cfg_in.debounce_ms       = csr_wdata;
            REG_DOUBLE:   cfg_in.double_window_ms  = csr_wdata;
            REG_LONG:     cfg_in.long_press_ms     = csr_wdata;
            REG_STARTUP:  cfg_in.startup_ignore_ms = csr_wdata;
            REG_GUARD:    cfg_in.guard_ms          = csr_wdata;
            REG_ACTLOW:   cfg_in.active_low        = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms       <= DEBOUNCE_RST;
         cfg_ff.double_window_ms  <= DOUBLE_RST;
         cfg_ff.long_press_ms     <= LONG_RST;
         cfg_ff.startup_ignore_ms <= STARTUP_RST;
         cfg_ff.guard_ms          <= GUARD_RST;
         cfg_ff.active_low        <= ACTLOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/core/bgc_core.sv @@
// Debounce and gesture classification state with its one-tick update logic.
`default_nettype none
module bgc_core #(
   parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic       pin_level,
   input  wire bgc_pkg::cfg_type cfg,
   output bgc_pkg::res_type res
);
   import bgc_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
   localparam logic [TIMER_WIDTH-1:0] AGE_MAX = {TIMER_WIDTH{1'b1}};

   logic [TIMER_WIDTH-1:0] startup_age_ff, startup_age_in;
   logic [TIMER_WIDTH-1:0] raw_age_ff, raw_age_in;
   logic [TIMER_WIDTH-1:0] press_age_ff, press_age_in;
   logic [TIMER_WIDTH-1:0] click_age_ff, click_age_in;
   logic [CFG_W-1:0]       guard_left_ff, guard_left_in;
   logic last_raw_ff, last_raw_in;
   logic stable_ff, stable_in;
   logic press_active_ff, press_active_in;
   logic long_fired_ff, long_fired_in;
   logic click_pending_ff, click_pending_in;
   logic double_armed_ff, double_armed_in;
   logic guard_active_ff, guard_active_in;

   logic             raw;
   logic [CFG_W-1:0] long_lim;
   logic [CFG_W-1:0] guard_dec;
   logic             in_startup;
   res_type          res_c;

   function automatic logic [TIMER_WIDTH-1:0] age_inc(input logic [TIMER_WIDTH-1:0] a);
      return (a == AGE_MAX) ? a : a + 1'b1;
   endfunction

   always_comb begin
      raw        = pin_level ^ cfg.active_low;
      long_lim   = (cfg.long_press_ms == '0) ? CFG_W'(1) : cfg.long_press_ms;
      in_startup = CMP_W'(startup_age_ff) < CMP_W'(cfg.startup_ignore_ms);
      guard_dec  = guard_left_ff - CFG_W'(guard_left_ff != '0);

      res_c.valid   = 1'b0;
      res_c.gesture = GEST_SHORT;

      startup_age_in   = age_inc(startup_age_ff);
      raw_age_in       = age_inc(raw_age_ff);
      press_age_in     = age_inc(press_age_ff);
      click_age_in     = age_inc(click_age_ff);
      guard_left_in    = guard_left_ff;
      last_raw_in      = last_raw_ff;
      stable_in        = stable_ff;
      press_active_in  = press_active_ff;
      long_fired_in    = long_fired_ff;
      click_pending_in = click_pending_ff;
      double_armed_in  = double_armed_ff;
      guard_active_in  = guard_active_ff;

      if (in_startup) begin
         // follow the raw level, no gestures
         last_raw_in      = raw;
         stable_in        = raw;
         raw_age_in       = '0;
         press_active_in  = raw;
         press_age_in     = '0;
         guard_active_in  = 1'b0;
         guard_left_in    = '0;
         long_fired_in    = 1'b0;
         click_pending_in = 1'b0;
         double_armed_in  = 1'b0;
      end else if (guard_active_ff && guard_dec != '0) begin
         guard_left_in = guard_dec;
         if (!raw) begin
            last_raw_in = 1'b0;
            stable_in   = 1'b0;
            raw_age_in  = '0;
         end
         press_active_in  = 1'b0;
         long_fired_in    = 1'b0;
         click_pending_in = 1'b0;
         double_armed_in  = 1'b0;
      end else begin
         if (guard_active_ff) begin
            guard_left_in   = guard_dec;
            guard_active_in = 1'b0;
         end

         if (raw != last_raw_ff) begin
            last_raw_in = raw;
            raw_age_in  = '0;
         end

         if (CMP_W'(raw_age_in) >= CMP_W'(cfg.debounce_ms) && raw != stable_ff) begin
            stable_in = raw;
            if (raw) begin
               if (click_pending_ff) begin
                  click_pending_in = 1'b0;
                  if (CMP_W'(click_age_in) <= CMP_W'(cfg.double_window_ms)) begin
                     double_armed_in = 1'b1;
                  end else begin
                     res_c.valid   = 1'b1;
                     res_c.gesture = GEST_SHORT;
                  end
               end
               press_active_in = 1'b1;
               press_age_in    = '0;
               long_fired_in   = 1'b0;
            end else begin
               if (!long_fired_ff) begin
                  if (double_armed_ff) begin
                     double_armed_in = 1'b0;
                     guard_active_in = 1'b1;
                     guard_left_in   = cfg.guard_ms;
                     res_c.valid     = 1'b1;
                     res_c.gesture   = GEST_DOUBLE;
                  end else begin
                     click_pending_in = 1'b1;
                     click_age_in     = '0;
                  end
               end
               press_active_in = 1'b0;
               long_fired_in   = 1'b0;
            end
         end

         if (!res_c.valid && stable_in && !long_fired_in && press_active_in &&
             CMP_W'(press_age_in) >= CMP_W'(long_lim)) begin
            long_fired_in    = 1'b1;
            click_pending_in = 1'b0;
            double_armed_in  = 1'b0;
            guard_active_in  = 1'b1;
            guard_left_in    = cfg.guard_ms;
            res_c.valid      = 1'b1;
            res_c.gesture    = GEST_LONG;
         end

         // single click resolves once the double window has run out
         if (!res_c.valid && click_pending_in && !stable_in &&
             CMP_W'(click_age_in) > CMP_W'(cfg.double_window_ms)) begin
            click_pending_in = 1'b0;
            res_c.valid      = 1'b1;
            res_c.gesture    = GEST_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_age_ff   <= '0;
         raw_age_ff       <= '0;
         press_age_ff     <= '0;
         click_age_ff     <= '0;
         guard_left_ff    <= '0;
         last_raw_ff      <= 1'b0;
         stable_ff        <= 1'b0;
         press_active_ff  <= 1'b0;
         long_fired_ff    <= 1'b0;
         click_pending_ff <= 1'b0;
         double_armed_ff  <= 1'b0;
         guard_active_ff  <= 1'b0;
      end else if (step_en) begin
         startup_age_ff   <= startup_age_in;
         raw_age_ff       <= raw_age_in;
         press_age_ff     <= press_age_in;
         click_age_ff     <= click_age_in;
         guard_left_ff    <= guard_left_in;
         last_raw_ff      <= last_raw_in;
         stable_ff        <= stable_in;
         press_active_ff  <= press_active_in;
         long_fired_ff    <= long_fired_in;
         click_pending_ff <= click_pending_in;
         double_armed_ff  <= double_armed_in;
         guard_active_ff  <= guard_active_in;
      end
   end

   assign res = res_c;

endmodule
`default_nettype wire

@@ rtl/core/button_gesture_classifier.sv @@
// A request is registered in the input register, then classified into the rsp register.
// Throughput: one request per cycle while no result stalls; one state update per request.
// A stalled result stops the core; the input register takes one more request, then blocks.
// Reset (synchronous, active high) clears valid and core state, loads default CSR values.
// After reset the first startup_ignore_ms requests only track the pin, never emit.
`default_nettype none
`include "button_gesture_classifier_assert.svh"
module button_gesture_classifier #(
   parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_pin_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_gesture,
   input  wire logic                          csr_we,
   input  wire logic [bgc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bgc_pkg::CFG_W-1:0]     csr_wdata
);
   import bgc_pkg::*;

   cfg_type cfg;
   res_type res;

   logic in_valid_ff, in_valid_in;
   logic in_level_ff, in_level_in;
   logic rsp_valid_ff, rsp_valid_in;
   gesture_type rsp_gesture_ff, rsp_gesture_in;
   logic advance;

   bgc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgc_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .pin_level (in_level_ff),
      .cfg       (cfg),
      .res       (res)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_level_in = in_level_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_level_in = req_pin_level;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_gesture_in = rsp_gesture_ff;
      if (advance) begin
         rsp_valid_in = res.valid;
         if (res.valid) begin
            rsp_gesture_in = res.gesture;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff    <= in_level_in;
      rsp_gesture_ff <= rsp_gesture_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = rsp_gesture_ff;

   `BGC_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ready, in_valid_ff && rsp_valid_ff)
   `BGC_ASSERT_NXT(a_held_request_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `BGC_ASSERT_NXT(a_result_registered, clock, reset, advance && res.valid, rsp_valid_ff)

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the button gesture classifier with random handshake gaps.
`timescale 1ns / 100ps
module tb;
   import bgc_pkg::*;

   localparam int TW          = TIMER_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int DRAIN_LIMIT = 2000;
   localparam int PRINT_CAP   = 40;
   localparam int PHASE_ITEMS = 100;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic [TW-1:0]        AGE_MAX      = '1;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_pin_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [1:0]           rsp_gesture;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [CFG_W-1:0]     csr_wdata     = '0;

   button_gesture_classifier uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pin_level (req_pin_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_gesture   (rsp_gesture),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   logic        pin_backlog[$];
   gesture_type gestures_due[$];
   int          pins_queued = 0;
   int          pins_taken  = 0;
   int          err_count   = 0;
   int          cycle_count = 0;
   bit          req_fire    = 1'b0;
   bit          send_gaps   = 1'b1;
   bit          recv_gaps   = 1'b1;
   int          send_hold   = 0;
   int          recv_hold   = 0;

   // stimulus-side copy of the timing in force
   bit pol;
   int db, dw, lp, gd;
   int phase_items;

   // predicted block state
   cfg_type       cfg_now;
   logic [TW-1:0] boot_age, raw_hold_age, press_hold_age, click_gap_age, guard_cnt;
   bit            raw_last, held, press_on, long_done, click_wait, dbl_armed, guard_on;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_error(input string what);
      err_count++;
      if (err_count <= PRINT_CAP)
         $display("%0t tb mismatch: %s", $realtime, what);
   endtask

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] a);
      return (a == AGE_MAX) ? a : a + 1'b1;
   endfunction

   function automatic void clear_predictor();
      cfg_now.debounce_ms       = DEBOUNCE_RST;
      cfg_now.double_window_ms  = DOUBLE_RST;
      cfg_now.long_press_ms     = LONG_RST;
      cfg_now.startup_ignore_ms = STARTUP_RST;
      cfg_now.guard_ms          = GUARD_RST;
      cfg_now.active_low        = ACTLOW_RST;
      boot_age       = '0;
      raw_hold_age   = '0;
      press_hold_age = '0;
      click_gap_age  = '0;
      guard_cnt      = '0;
      raw_last       = 1'b0;
      held           = 1'b0;
      press_on       = 1'b0;
      long_done      = 1'b0;
      click_wait     = 1'b0;
      dbl_armed      = 1'b0;
      guard_on       = 1'b0;
   endfunction

   // One tick of the classifier; at most one gesture comes out.
   function automatic void classify_tick(input logic pin, output bit fired,
                                         output gesture_type g);
      bit            raw;
      logic [TW-1:0] elapsed;
      logic [TW-1:0] long_lim;
      raw      = cfg_now.active_low ? !pin : pin;
      elapsed  = boot_age;
      long_lim = (cfg_now.long_press_ms == '0) ? CFG_W'(1) : cfg_now.long_press_ms;
      fired    = 1'b0;
      g        = GEST_SHORT;

      boot_age       = sat_inc(boot_age);
      raw_hold_age   = sat_inc(raw_hold_age);
      press_hold_age = sat_inc(press_hold_age);
      click_gap_age  = sat_inc(click_gap_age);

      if (elapsed < cfg_now.startup_ignore_ms) begin
         raw_last       = raw;
         held           = raw;
         raw_hold_age   = '0;
         press_on       = raw;
         press_hold_age = '0;
         guard_on       = 1'b0;
         guard_cnt      = '0;
         long_done      = 1'b0;
         click_wait     = 1'b0;
         dbl_armed      = 1'b0;
         return;
      end

      if (guard_on) begin
         if (guard_cnt != '0)
            guard_cnt = guard_cnt - 1'b1;
         if (guard_cnt != '0) begin
            // a release during the guard still clears the debounced level
            if (!raw) begin
               raw_last     = 1'b0;
               held         = 1'b0;
               raw_hold_age = '0;
            end
            press_on   = 1'b0;
            long_done  = 1'b0;
            click_wait = 1'b0;
            dbl_armed  = 1'b0;
            return;
         end
         guard_on = 1'b0;
      end

      if (raw != raw_last) begin
         raw_last     = raw;
         raw_hold_age = '0;
      end

      if (raw_hold_age >= cfg_now.debounce_ms && raw != held) begin
         held = raw;
         if (raw) begin
            if (click_wait) begin
               click_wait = 1'b0;
               if (click_gap_age <= cfg_now.double_window_ms) begin
                  dbl_armed = 1'b1;
               end else begin
                  fired = 1'b1;
                  g     = GEST_SHORT;
               end
            end
            press_on       = 1'b1;
            press_hold_age = '0;
            long_done      = 1'b0;
         end else begin
            if (!long_done) begin
               if (dbl_armed) begin
                  dbl_armed = 1'b0;
                  guard_on  = 1'b1;
                  guard_cnt = cfg_now.guard_ms;
                  fired     = 1'b1;
                  g         = GEST_DOUBLE;
               end else begin
                  click_wait    = 1'b1;
                  click_gap_age = '0;
               end
            end
            press_on  = 1'b0;
            long_done = 1'b0;
         end
      end

      if (!fired && held && !long_done && press_on && press_hold_age >= long_lim) begin
         long_done  = 1'b1;
         click_wait = 1'b0;
         dbl_armed  = 1'b0;
         guard_on   = 1'b1;
         guard_cnt  = cfg_now.guard_ms;
         fired      = 1'b1;
         g          = GEST_LONG;
      end

      if (!fired && click_wait && !held && click_gap_age > cfg_now.double_window_ms) begin
         click_wait = 1'b0;
         fired      = 1'b1;
         g          = GEST_SHORT;
      end
   endfunction

   always @(posedge clock) begin : monitor
      bit          fired;
      gesture_type g;
      if (reset) begin
         clear_predictor();
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (gestures_due.size() == 0) begin
               flag_error($sformatf("gesture %0d with none expected", rsp_gesture));
            end else begin
               g = gestures_due.pop_front();
               if (rsp_gesture !== g)
                  flag_error($sformatf("gesture %0d, expected %s", rsp_gesture, g.name()));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_DEBOUNCE: cfg_now.debounce_ms       = csr_wdata;
               REG_DOUBLE:   cfg_now.double_window_ms  = csr_wdata;
               REG_LONG:     cfg_now.long_press_ms     = csr_wdata;
               REG_STARTUP:  cfg_now.startup_ignore_ms = csr_wdata;
               REG_GUARD:    cfg_now.guard_ms          = csr_wdata;
               REG_ACTLOW:   cfg_now.active_low        = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pins_taken++;
            classify_tick(req_pin_level, fired, g);
            if (fired)
               gestures_due.push_back(g);
         end
      end
   end

   // next request goes out once the slot is free
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else if (!req_valid || req_fire) begin
         if (send_hold > 0) begin
            send_hold--;
            req_valid <= 1'b0;
         end else if (pin_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (send_gaps && $urandom_range(0, 5) == 0) begin
            send_hold = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            req_valid     <= 1'b1;
            req_pin_level <= pin_backlog.pop_front();
         end
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
         recv_hold = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] d_db, input logic [CFG_W-1:0] d_dw,
                             input logic [CFG_W-1:0] d_lp, input logic [CFG_W-1:0] d_st,
                             input logic [CFG_W-1:0] d_gd, input bit d_pol);
      logic [CFG_W-1:0] junk;
      write_reg(REG_DEBOUNCE, d_db);
      write_reg(REG_DOUBLE, d_dw);
      write_reg(REG_LONG, d_lp);
      write_reg(REG_STARTUP, d_st);
      write_reg(REG_GUARD, d_gd);
      // upper bits of the polarity write are don't-care
      junk    = CFG_W'($urandom);
      junk[0] = d_pol;
      write_reg(REG_ACTLOW, junk);
      junk = CFG_W'($urandom);
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, junk);
      db  = int'(d_db);
      dw  = int'(d_dw);
      lp  = int'(d_lp);
      gd  = int'(d_gd);
      pol = d_pol;
   endtask

   task automatic hold_level(input bit pressed, input int n);
      repeat (n) begin
         pin_backlog.push_back(pressed ^ pol);
         pins_queued++;
         phase_items++;
      end
   endtask

   task automatic chatter(input int n);
      repeat (n) begin
         pin_backlog.push_back(1'($urandom_range(0, 1)));
         pins_queued++;
         phase_items++;
      end
   endtask

   task automatic one_gesture();
      int lpe;
      lpe = (lp < 1) ? 1 : lp;
      if ($urandom_range(0, 3) == 0)
         chatter($urandom_range(1, 3));
      case ($urandom_range(0, 6))
         0, 1: begin
            hold_level(1'b1, db + $urandom_range(1, lpe));
            hold_level(1'b0, db + $urandom_range(1, dw + 4));
         end
         2: begin
            hold_level(1'b1, db + lpe + $urandom_range(1, 4));
            hold_level(1'b0, db + gd + $urandom_range(1, 4));
         end
         3, 4: begin
            hold_level(1'b1, db + $urandom_range(1, lpe));
            hold_level(1'b0, db + $urandom_range(1, dw + 1));
            hold_level(1'b1, db + $urandom_range(1, lpe));
            hold_level(1'b0, db + gd + $urandom_range(1, dw + 4));
         end
         5: begin
            // second press lands around the end of the double window
            hold_level(1'b1, db + $urandom_range(1, lpe));
            hold_level(1'b0, db + dw + $urandom_range(0, 2));
            hold_level(1'b1, db + 1);
            hold_level(1'b0, db + gd + dw + 3);
         end
         default: chatter($urandom_range(2, 10));
      endcase
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while (pins_taken != pins_queued)
         @(negedge clock);
      while (gestures_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (gestures_due.size() != 0) begin
         flag_error($sformatf("%0d expected gestures never came", gestures_due.size()));
         gestures_due.delete();
      end
      // a tick with no gesture may still be in the pipe
      repeat (8) @(negedge clock);
   endtask

   task automatic random_phase(input bit gaps);
      send_gaps = gaps && ($urandom_range(0, 3) != 0);
      recv_gaps = gaps && ($urandom_range(0, 3) != 0);
      set_timing(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 24)),
                 CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 3)),
                 CFG_W'($urandom_range(0, 10)), 1'($urandom_range(0, 1)));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS)
         one_gesture();
      drain();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // zero debounce, zero long time, zero guard, pin high is pressed
      set_timing(0, 2, 0, 4, 0, 1'b0);
      hold_level(1'b1, 2);
      hold_level(1'b0, 2);
      hold_level(1'b1, 2);
      hold_level(1'b0, 2);
      hold_level(1'b1, 1);
      hold_level(1'b0, 1);
      hold_level(1'b1, 1);
      hold_level(1'b0, 2);
      hold_level(1'b1, 1);
      hold_level(1'b0, 4);
      // press one tick too late: short reported at the press itself
      hold_level(1'b1, 1);
      hold_level(1'b0, 3);
      hold_level(1'b1, 1);
      hold_level(1'b0, 1);
      drain();

      repeat (4) random_phase(1'b1);

      // debounce at maximum: nothing ever settles
      set_timing(16'hFFFF, 5, 5, 0, 2, 1'b1);
      chatter(30);
      hold_level(1'b1, 20);
      hold_level(1'b0, 20);
      drain();

      // long time at maximum: a long hold ends as a plain click
      set_timing(1, 4, 16'hFFFF, 0, 3, 1'b0);
      hold_level(1'b1, 60);
      hold_level(1'b0, 10);
      drain();

      // startup window reopened before the startup counter saturates
      set_timing(2, 4, 3, 16'hFFFF, 3, 1'b1);
      chatter(20);
      hold_level(1'b1, 10);
      hold_level(1'b0, 10);
      drain();

      // guard at maximum after a long press: everything after it is ignored
      set_timing(1, 4, 3, 0, 16'hFFFF, 1'b1);
      hold_level(1'b1, 8);
      chatter(100);
      hold_level(1'b0, 20);
      drain();

      // double window at maximum: a late second press still arms a double
      set_timing(1, 16'hFFFF, 10, 0, 2, 1'b0);
      hold_level(1'b1, 3);
      hold_level(1'b0, 40);
      hold_level(1'b1, 3);
      hold_level(1'b0, 6);
      drain();

      // startup window at maximum: requests only track the pin
      set_timing(0, 0, 2, 16'hFFFF, 0, 1'b1);
      phase_items = 0;
      repeat (8) one_gesture();
      drain();

      repeat (2) random_phase(1'b1);
      repeat (2) random_phase(1'b0);

      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bgc_pkg.sv
rtl/core/bgc_cfg.sv
rtl/core/bgc_core.sv
rtl/core/button_gesture_classifier.sv
test/tb.sv
